@@ rtl/resident_byte_accounting_macros.svh @@
// ----------------------------------------------------------------------------
// Resident byte accounting: assertion macros
// Concurrent assertion shorthands used at the end of the top level. They are
// clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESIDENT_BYTE_ACCOUNTING_MACROS_SVH
`define RESIDENT_BYTE_ACCOUNTING_MACROS_SVH

`ifndef SYNTHESIS

// Consequent checked in the same cycle as the antecedent.
`define RBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define RBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RBA_ASSERT_NOW(label, ante, cons)
`define RBA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/rba_pkg.sv @@
// ----------------------------------------------------------------------------
// Resident byte accounting package
// Shared constants and types: kind count, counter width, operation codes and
// the per-kind counter entry held in the kind memory.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int KIND_COUNT = 5;
  localparam int KIND_IDX_W = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
  localparam int CNT_W      = 64;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLONE   = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] live;
    logic [CNT_W-1:0] peak;
    logic [CNT_W-1:0] acquired;
  } kind_entry_t;

  typedef struct packed {
    logic                  en;
    logic [KIND_IDX_W-1:0] idx;
    kind_entry_t           data;
  } kind_wr_t;

endpackage

@@ rtl/rba_kind_mem.sv @@
// ----------------------------------------------------------------------------
// Resident byte accounting: per-kind counter memory
// One read and one write port, registered read. Per-entry valid bits make an
// entry read as zero until it is first written after reset.
// ----------------------------------------------------------------------------
module rba_kind_mem
  import rba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [KIND_IDX_W-1:0] rd_idx,
  output kind_entry_t           rd_data,
  input  kind_wr_t              wr
);

  kind_entry_t           kind_ram [KIND_COUNT];
  kind_entry_t           rd_q_r;
  logic                  rd_hit_r;
  logic [KIND_COUNT-1:0] kvalid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      kind_ram[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= kind_ram[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kvalid_r <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        kvalid_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= kvalid_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : '0;

endmodule

@@ rtl/resident_byte_accounting.sv @@
// ----------------------------------------------------------------------------
// Resident byte accounting
// Per-kind live, peak and acquired byte counters plus totals, clone crossing
// statistics and an underflow count, updated one transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): operation, kind, bytes. Operations are
//   acquire, release and record clone crossing. Zero bytes, an unused
//   operation code, or an out-of-range kind on acquire/release is a no-op
//   read and reports ignored.
//   Result channel (out_valid/out_ready): one result transaction per input,
//   carrying the named kind's counters after the update and all totals.
//   The kind memory read is issued at the accepting edge; update and
//   write-back happen at the edge that raises out_valid, once the output
//   register is free. in_ready drops for the update cycle so that the next
//   read sees the written-back entry, so a new transaction is not taken
//   until the previous one has been updated.
//   A new transaction may be taken while the previous result still waits in
//   the output register; its update holds off until that result is taken,
//   so a stalled receiver holds at most two transactions inside the block.
//   Reset (rst_n low, synchronous) zeroes every counter at once: the kind
//   memory entries read as zero until written, no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "resident_byte_accounting_macros.svh"

module resident_byte_accounting
  import rba_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [3:0]       in_kind,
  input  logic [CNT_W-1:0] in_bytes,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_ignored,
  output logic             out_clamped,
  output logic [CNT_W-1:0] out_kind_live,
  output logic [CNT_W-1:0] out_kind_peak,
  output logic [CNT_W-1:0] out_kind_acquired,
  output logic [CNT_W-1:0] out_total_live,
  output logic [CNT_W-1:0] out_total_peak,
  output logic [CNT_W-1:0] out_clone_byte_sum,
  output logic [CNT_W-1:0] out_clone_count,
  output logic [CNT_W-1:0] out_underflow_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Transaction held across the memory read
  logic [1:0]       op_r;
  logic [3:0]       kind_r;
  logic [CNT_W-1:0] bytes_r;

  // Totals live in flops: single entries, read every transaction
  logic [CNT_W-1:0] live_sum_r, live_sum_nxt;
  logic [CNT_W-1:0] peak_sum_r, peak_sum_nxt;
  logic [CNT_W-1:0] clone_bytes_r, clone_bytes_nxt;
  logic [CNT_W-1:0] clone_events_r, clone_events_nxt;
  logic [CNT_W-1:0] underflow_r, underflow_nxt;

  // Output register
  logic        out_valid_r;
  logic        ignored_r, clamped_r;
  kind_entry_t kind_out_r;

  logic                  in_fire;
  logic                  commit;
  logic                  out_free;
  logic                  kind_ok_in;
  logic                  kind_ok;
  logic                  is_acq, is_rel, is_clone;
  logic                  bytes_zero;
  logic                  acq_do, rel_do, clone_do;
  logic                  short_kind, short_sum;
  logic                  ignored_nxt;
  logic [KIND_IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0]      live_add;
  logic [CNT_W-1:0]      sum_add;
  kind_entry_t           cur, upd;
  kind_wr_t              wr;

  // Kind compare is one bit wider so that a count of 16 still works
  assign kind_ok_in = {1'b0, in_kind} < 5'(KIND_COUNT);
  assign kind_ok    = {1'b0, kind_r}  < 5'(KIND_COUNT);

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == S_CALC) && out_free;

  // Out-of-range kinds read entry 0; the result masks them to zero anyway
  assign rd_idx = kind_ok_in ? in_kind[KIND_IDX_W-1:0] : '0;

  rba_kind_mem u_kind_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_idx  (rd_idx),
    .rd_data (cur),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_operation;
      kind_r  <= in_kind;
      bytes_r <= in_bytes;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CALC;
      S_CALC:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Update datapath
  always_comb begin
    bytes_zero = (bytes_r == '0);
    is_acq     = (op_r == OP_ACQUIRE);
    is_rel     = (op_r == OP_RELEASE);
    is_clone   = (op_r == OP_CLONE);
    acq_do     = !bytes_zero && is_acq && kind_ok;
    rel_do     = !bytes_zero && is_rel && kind_ok;
    clone_do   = !bytes_zero && is_clone;

    ignored_nxt = bytes_zero || ((is_acq || is_rel) && !kind_ok) ||
                  !(is_acq || is_rel || is_clone);

    live_add   = cur.live + bytes_r;
    sum_add    = live_sum_r + bytes_r;
    short_kind = cur.live < bytes_r;
    short_sum  = live_sum_r < bytes_r;

    upd              = cur;
    live_sum_nxt     = live_sum_r;
    peak_sum_nxt     = peak_sum_r;
    clone_bytes_nxt  = clone_bytes_r;
    clone_events_nxt = clone_events_r;
    underflow_nxt    = underflow_r;

    if (acq_do) begin
      upd.live     = live_add;
      upd.peak     = (cur.peak < live_add) ? live_add : cur.peak;
      upd.acquired = cur.acquired + bytes_r;
      live_sum_nxt = sum_add;
      peak_sum_nxt = (peak_sum_r < sum_add) ? sum_add : peak_sum_r;
    end
    if (rel_do) begin
      upd.live     = short_kind ? '0 : cur.live - bytes_r;
      live_sum_nxt = short_sum ? '0 : live_sum_r - bytes_r;
      if (short_kind) begin
        underflow_nxt = underflow_r + CNT_W'(1);
      end
    end
    if (clone_do) begin
      clone_bytes_nxt  = clone_bytes_r + bytes_r;
      clone_events_nxt = clone_events_r + CNT_W'(1);
    end

    wr.en   = commit && (acq_do || rel_do);
    wr.idx  = kind_r[KIND_IDX_W-1:0];
    wr.data = upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      live_sum_r     <= '0;
      peak_sum_r     <= '0;
      clone_bytes_r  <= '0;
      clone_events_r <= '0;
      underflow_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r    <= 1'b1;
        live_sum_r     <= live_sum_nxt;
        peak_sum_r     <= peak_sum_nxt;
        clone_bytes_r  <= clone_bytes_nxt;
        clone_events_r <= clone_events_nxt;
        underflow_r    <= underflow_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      ignored_r  <= ignored_nxt;
      clamped_r  <= rel_do && short_kind;
      kind_out_r <= kind_ok ? upd : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ignored         = ignored_r;
  assign out_clamped         = clamped_r;
  assign out_kind_live       = kind_out_r.live;
  assign out_kind_peak       = kind_out_r.peak;
  assign out_kind_acquired   = kind_out_r.acquired;
  assign out_total_live      = live_sum_r;
  assign out_total_peak      = peak_sum_r;
  assign out_clone_byte_sum  = clone_bytes_r;
  assign out_clone_count     = clone_events_r;
  assign out_underflow_count = underflow_r;

  // Assertions
  `RBA_ASSERT_NEXT(a_fire_to_calc, in_fire, state_r == S_CALC)
  `RBA_ASSERT_NEXT(a_commit_shows, commit, out_valid_r)
  `RBA_ASSERT_NOW(a_peak_covers_live, 1'b1, peak_sum_r >= live_sum_r)
  `RBA_ASSERT_NOW(a_clamp_not_ignored, out_valid_r && clamped_r, !ignored_r)

endmodule

@@ tb/sv/resident_byte_accounting_tb.sv @@
// ----------------------------------------------------------------------------
// Resident byte accounting testbench
// Drives acquire, release and clone crossing transactions into the block and
// checks every result transaction against a cycle-free predictor of the
// per-kind and total counters. Runs a directed opening, then random lease
// sequences mixed with noise, under changing sender and receiver idling and
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module resident_byte_accounting_tb;
  import rba_pkg::*;

  // op code 3 has no meaning in the block; it must read as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CNT_W-1:0] ALL_ONES = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    PH_FREE,       // no idling on either side
    PH_SEND_IDLE,  // sender idle most cycles
    PH_RECV_STALL, // receiver stalling most cycles
    PH_BOTH,       // light idling on both sides
    PH_PRESSURE    // sender flat out, receiver held off
  } phase_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [3:0]       kind;
    logic [CNT_W-1:0] bytes;
  } request_t;

  typedef struct packed {
    logic             ignored;
    logic             clamped;
    logic [CNT_W-1:0] kind_live;
    logic [CNT_W-1:0] kind_peak;
    logic [CNT_W-1:0] kind_acquired;
    logic [CNT_W-1:0] total_live;
    logic [CNT_W-1:0] total_peak;
    logic [CNT_W-1:0] clone_byte_sum;
    logic [CNT_W-1:0] clone_count;
    logic [CNT_W-1:0] underflow_count;
  } tally_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_operation = OP_ACQUIRE;
  logic [3:0]       in_kind = 4'd0;
  logic [CNT_W-1:0] in_bytes = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_ignored;
  logic             out_clamped;
  logic [CNT_W-1:0] out_kind_live;
  logic [CNT_W-1:0] out_kind_peak;
  logic [CNT_W-1:0] out_kind_acquired;
  logic [CNT_W-1:0] out_total_live;
  logic [CNT_W-1:0] out_total_peak;
  logic [CNT_W-1:0] out_clone_byte_sum;
  logic [CNT_W-1:0] out_clone_count;
  logic [CNT_W-1:0] out_underflow_count;

  resident_byte_accounting dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_kind             (in_kind),
    .in_bytes            (in_bytes),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ignored         (out_ignored),
    .out_clamped         (out_clamped),
    .out_kind_live       (out_kind_live),
    .out_kind_peak       (out_kind_peak),
    .out_kind_acquired   (out_kind_acquired),
    .out_total_live      (out_total_live),
    .out_total_peak      (out_total_peak),
    .out_clone_byte_sum  (out_clone_byte_sum),
    .out_clone_count     (out_clone_count),
    .out_underflow_count (out_underflow_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  phase_t   phase = PH_FREE;
  logic     receiver_hold = 1'b0;
  int       mismatches = 0;
  request_t pending_txns[$];      // waiting to be offered
  tally_t   expected_tallies[$];  // predicted, waiting for the result channel
  request_t offered;              // payload currently on the input channel

  // Shadow of the block's counters, advanced at each accepted transaction
  logic [CNT_W-1:0] kind_live_bytes [KIND_COUNT];
  logic [CNT_W-1:0] kind_peak_bytes [KIND_COUNT];
  logic [CNT_W-1:0] kind_acq_bytes  [KIND_COUNT];
  logic [CNT_W-1:0] sum_live_bytes;
  logic [CNT_W-1:0] sum_peak_bytes;
  logic [CNT_W-1:0] clone_bytes;
  logic [CNT_W-1:0] clone_crossings;
  logic [CNT_W-1:0] underflow_hits;

  initial begin
    for (int i = 0; i < KIND_COUNT; i++) begin
      kind_live_bytes[i] = '0;
      kind_peak_bytes[i] = '0;
      kind_acq_bytes[i]  = '0;
    end
    sum_live_bytes  = '0;
    sum_peak_bytes  = '0;
    clone_bytes     = '0;
    clone_crossings = '0;
    underflow_hits  = '0;
  end

  // Applies one transaction to the shadow counters and returns what the
  // block should report for it.
  function automatic tally_t account(request_t r);
    tally_t t;
    bit     in_range;
    t = '0;
    in_range = (r.kind < KIND_COUNT);
    if (r.bytes == '0) begin
      t.ignored = 1'b1;
    end else if (r.op == OP_ACQUIRE || r.op == OP_RELEASE) begin
      if (!in_range) begin
        t.ignored = 1'b1;
      end else if (r.op == OP_ACQUIRE) begin
        // adds wrap; a wrapped live value only raises a peak if it is higher
        kind_live_bytes[r.kind] = kind_live_bytes[r.kind] + r.bytes;
        if (kind_peak_bytes[r.kind] < kind_live_bytes[r.kind])
          kind_peak_bytes[r.kind] = kind_live_bytes[r.kind];
        kind_acq_bytes[r.kind] = kind_acq_bytes[r.kind] + r.bytes;
        sum_live_bytes = sum_live_bytes + r.bytes;
        if (sum_peak_bytes < sum_live_bytes)
          sum_peak_bytes = sum_live_bytes;
      end else begin
        if (kind_live_bytes[r.kind] < r.bytes) begin
          kind_live_bytes[r.kind] = '0;
          underflow_hits = underflow_hits + CNT_W'(1);
          t.clamped = 1'b1;
        end else begin
          kind_live_bytes[r.kind] = kind_live_bytes[r.kind] - r.bytes;
        end
        // total clamps silently, no underflow for it
        if (sum_live_bytes < r.bytes)
          sum_live_bytes = '0;
        else
          sum_live_bytes = sum_live_bytes - r.bytes;
      end
    end else if (r.op == OP_CLONE) begin
      clone_bytes     = clone_bytes + r.bytes;
      clone_crossings = clone_crossings + CNT_W'(1);
    end else begin
      t.ignored = 1'b1;
    end
    if (in_range) begin
      t.kind_live     = kind_live_bytes[r.kind];
      t.kind_peak     = kind_peak_bytes[r.kind];
      t.kind_acquired = kind_acq_bytes[r.kind];
    end
    t.total_live      = sum_live_bytes;
    t.total_peak      = sum_peak_bytes;
    t.clone_byte_sum  = clone_bytes;
    t.clone_count     = clone_crossings;
    t.underflow_count = underflow_hits;
    return t;
  endfunction

  function automatic bit sender_idle();
    case (phase)
      PH_SEND_IDLE: return $urandom_range(99) < 88;
      PH_BOTH:      return $urandom_range(99) < 11;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (phase)
      PH_RECV_STALL: return $urandom_range(99) < 88;
      PH_BOTH:       return $urandom_range(99) < 11;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic request_t make_req(logic [1:0] op, logic [3:0] kind,
                                        logic [CNT_W-1:0] bytes);
    request_t r;
    r.op    = op;
    r.kind  = kind;
    r.bytes = bytes;
    return r;
  endfunction

  // Noise transaction: any op, mostly valid kinds, amounts from tiny to
  // full width and near the wrap point.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 42)      r.op = OP_ACQUIRE;
    else if (pick < 78) r.op = OP_RELEASE;
    else if (pick < 94) r.op = OP_CLONE;
    else                r.op = OP_UNUSED;
    if ($urandom_range(99) < 85) r.kind = 4'($urandom_range(KIND_COUNT - 1));
    else                         r.kind = 4'($urandom_range(15, KIND_COUNT));
    pick = $urandom_range(99);
    if (pick < 5)       r.bytes = '0;
    else if (pick < 60) r.bytes = CNT_W'($urandom_range(4096, 1));
    else if (pick < 82) r.bytes = CNT_W'($urandom_range(1 << 20, 1));
    else if (pick < 96) r.bytes = {$urandom, $urandom};
    else                r.bytes = ALL_ONES - CNT_W'($urandom_range(4096));
    return r;
  endfunction

  // Mostly lease sequences: an acquire on one kind then releases that hand
  // it back in pieces, the last piece exact, short or over by a little.
  task automatic queue_random(int count);
    int          pushed;
    int unsigned lease;
    int unsigned left;
    int unsigned piece;
    int unsigned parts;
    logic [3:0]  kind;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(99) < 60) begin
        kind  = 4'($urandom_range(KIND_COUNT - 1));
        lease = $urandom_range(100000, 1);
        pending_txns.push_back(make_req(OP_ACQUIRE, kind, CNT_W'(lease)));
        pushed++;
        parts = $urandom_range(3, 1);
        left  = lease;
        for (int i = 1; i < parts; i++) begin
          piece = (left > 1) ? $urandom_range(left - 1, 1) : left;
          pending_txns.push_back(make_req(OP_RELEASE, kind, CNT_W'(piece)));
          left -= piece;
          pushed++;
        end
        case ($urandom_range(2))
          0:       piece = left;
          1:       piece = left + $urandom_range(50, 1);
          default: piece = (left > 1) ? left - 1 : left;
        endcase
        pending_txns.push_back(make_req(OP_RELEASE, kind, CNT_W'(piece)));
        pushed++;
      end else begin
        pending_txns.push_back(random_request());
        pushed++;
      end
    end
  endtask

  task automatic run_phase(phase_t ph, int count);
    phase <= ph;
    queue_random(count);
    while (pending_txns.size() != 0) @(posedge clk);
  endtask

  // Driver: predicts on acceptance, then offers the next pending transaction
  // unless the sender idles this cycle. in_valid gets one assignment per edge.
  always @(posedge clk) begin
    tally_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        t = account(offered);
        expected_tallies.push_back(t);
      end
      if (!in_valid || in_ready) begin
        if (pending_txns.size() != 0 && !sender_idle()) begin
          offered = pending_txns.pop_front();
          in_valid     <= 1'b1;
          in_operation <= offered.op;
          in_kind      <= offered.kind;
          in_bytes     <= offered.bytes;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result transaction with the oldest
  // prediction, then decides out_ready for the next cycle.
  always @(posedge clk) begin
    tally_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_tallies.pop_front();
          check_field("ignored", CNT_W'(want.ignored), CNT_W'(out_ignored));
          check_field("clamped", CNT_W'(want.clamped), CNT_W'(out_clamped));
          check_field("kind_live", want.kind_live, out_kind_live);
          check_field("kind_peak", want.kind_peak, out_kind_peak);
          check_field("kind_acquired", want.kind_acquired, out_kind_acquired);
          check_field("total_live", want.total_live, out_total_live);
          check_field("total_peak", want.total_peak, out_total_peak);
          check_field("clone_byte_sum", want.clone_byte_sum, out_clone_byte_sum);
          check_field("clone_count", want.clone_count, out_clone_count);
          check_field("underflow_count", want.underflow_count,
                      out_underflow_count);
        end
      end
      out_ready <= !receiver_hold && !receiver_stall();
    end
  end

  // Long receiver hold-off: the sender keeps offering, the block fills and
  // must drop in_ready until the hold lifts.
  initial begin
    wait (phase == PH_PRESSURE);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (300) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd0, '0));        // zero bytes
    pending_txns.push_back(make_req(OP_RELEASE, 4'd0, 64'd100));   // clamp from empty
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd0, 64'd1000));
    pending_txns.push_back(make_req(OP_RELEASE, 4'd0, 64'd400));
    pending_txns.push_back(make_req(OP_RELEASE, 4'd0, 64'd600));   // exact, no clamp
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd4, 64'd500));   // top valid kind
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd5, 64'd77));    // kind out of range
    pending_txns.push_back(make_req(OP_RELEASE, 4'd15, 64'd10));
    pending_txns.push_back(make_req(OP_CLONE, 4'd3, 64'd123));
    pending_txns.push_back(make_req(OP_CLONE, 4'd15, 64'd456));    // clone, bad kind
    pending_txns.push_back(make_req(OP_CLONE, 4'd0, '0));
    pending_txns.push_back(make_req(OP_UNUSED, 4'd1, 64'd99));     // unused op code
    pending_txns.push_back(make_req(OP_UNUSED, 4'd7, '0));
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd1, ALL_ONES));
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd1, 64'd2));     // live wraps below peak
    pending_txns.push_back(make_req(OP_RELEASE, 4'd2, ALL_ONES));
    pending_txns.push_back(make_req(OP_RELEASE, 4'd4, 64'd1000));  // clamp, total too
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd2, 64'h8000_0000_0000_0000));
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd3, 64'h8000_0000_0000_0100));
    // kind covers it but the wrapped total does not: total clamp only
    pending_txns.push_back(make_req(OP_RELEASE, 4'd3, 64'h8000_0000_0000_0000));
    pending_txns.push_back(make_req(OP_CLONE, 4'd4, ALL_ONES));
    pending_txns.push_back(make_req(OP_CLONE, 4'd2, 64'd1));       // clone sum back above its wrap
    pending_txns.push_back(make_req(OP_ACQUIRE, 4'd1, 64'd1));
    while (pending_txns.size() != 0) @(posedge clk);

    run_phase(PH_FREE, 120);
    run_phase(PH_SEND_IDLE, 140);
    run_phase(PH_RECV_STALL, 140);
    run_phase(PH_BOTH, 180);
    run_phase(PH_PRESSURE, 80);
    run_phase(PH_FREE, 140);

    while (expected_tallies.size() != 0 || in_valid) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_tallies.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("resident_byte_accounting verification clean");
    end else begin
      $display("resident_byte_accounting verification failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2400000;
    $display("resident_byte_accounting verification failed");
    $finish;
  end

endmodule
